### rtl/core/ffs_pkg.sv
// Shared types, constants and helper functions for the face flux stencil.
package ffs_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int COEF_W    = 31;
	localparam int LIM_BITS  = 56;
	localparam int MA_W      = WORD_BITS + 2;
	localparam int V_W       = LIM_BITS + 2;
	localparam int X_W       = LIM_BITS + 6;
	localparam int QDEPTH    = 2;

	localparam logic [1:0] REG_AXIS     = 2'd0;
	localparam logic [1:0] REG_COMPRESS = 2'd1;
	localparam logic [1:0] REG_VISC     = 2'd2;
	localparam logic [1:0] REG_AREA     = 2'd3;

	localparam logic [1:0] AXIS_X      = 2'd0;
	localparam logic [1:0] AXIS_Y      = 2'd1;
	localparam logic [1:0] AXIS_Z      = 2'd2;
	localparam logic [1:0] AXIS_UNUSED = 2'd3;

	localparam logic [1:0] VEL_X = 2'd1;
	localparam logic [1:0] VEL_Y = 2'd2;
	localparam logic [1:0] VEL_Z = 2'd3;

	localparam logic [COEF_W-1:0] COMPRESS_RST = COEF_W'(6553600);
	localparam logic [COEF_W-1:0] AREA_RST     = COEF_W'(1) << FRAC_BITS;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [MA_W-1:0]      mw_t;
	typedef logic signed [V_W-1:0]       vw_t;
	typedef logic signed [X_W-1:0]       xw_t;

	localparam vw_t ILIM = vw_t'({LIM_BITS{1'b1}});
	localparam vw_t WMAX = vw_t'({(WORD_BITS-1){1'b1}});
	localparam vw_t WMIN = -WMAX - vw_t'(1);

	typedef struct packed {
		word_t p;
		word_t vx;
		word_t vy;
		word_t vz;
	} cell_t;

	typedef struct packed {
		logic  line_start;
		word_t pressure;
		word_t vel_x;
		word_t vel_y;
		word_t vel_z;
	} in_word_t;

	typedef struct packed {
		word_t pressure_flux;
		word_t xmom_flux;
		word_t ymom_flux;
		word_t zmom_flux;
	} out_word_t;

	typedef struct packed {
		cell_t ll;
		cell_t l;
		cell_t r;
		cell_t rr;
	} task_t;

	typedef struct packed {
		logic [1:0]        axis;
		logic [COEF_W-1:0] compress_coef;
		logic [COEF_W-1:0] visc_coef;
		logic [COEF_W-1:0] face_area;
	} cfg_t;

	function automatic word_t vel_sel(cell_t c, logic [1:0] k);
		word_t v;
		unique case (k)
			VEL_X:   v = c.vx;
			VEL_Y:   v = c.vy;
			default: v = c.vz;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] normal_sel(logic [1:0] axis);
		logic [1:0] n;
		unique case (axis)
			AXIS_X:  n = VEL_X;
			AXIS_Y:  n = VEL_Y;
			default: n = VEL_Z;
		endcase
		return n;
	endfunction

	function automatic word_t sat_word(vw_t x);
		vw_t c;
		c = x;
		if (x > WMAX) c = WMAX;
		if (x < WMIN) c = WMIN;
		return c[WORD_BITS-1:0];
	endfunction

endpackage

### rtl/core/ffs_front.sv
// Front end: cell window along a line, emits one stencil task per full window.
module ffs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ffs_pkg::in_word_t item,
	output logic             full,
	output logic             task_push,
	output ffs_pkg::task_t   task_word,
	input  logic             task_full
);
	import ffs_pkg::*;

	logic [1:0] cnt_q;
	logic [1:0] eff;
	logic       accept;
	cell_t      cur;
	cell_t      win_q [3];

	assign full   = task_full;
	assign accept = push && !task_full;
	assign eff    = item.line_start ? 2'd0 : cnt_q;
	assign cur    = '{p: item.pressure, vx: item.vel_x, vy: item.vel_y, vz: item.vel_z};

	assign task_push = accept && (eff == 2'd3);
	assign task_word = '{ll: win_q[0], l: win_q[1], r: win_q[2], rr: cur};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept && eff != 2'd3) begin
			cnt_q <= eff + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (eff != 2'd3) begin
				win_q[eff] <= cur;
			end else begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= cur;
			end
		end
	end

endmodule

### rtl/core/ffs_task_fifo.sv
// Short task queue between front end and compute back end.
module ffs_task_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  ffs_pkg::task_t wdata,
	output logic           full,
	input  logic           rd,
	output logic           valid,
	output ffs_pkg::task_t rdata
);
	import ffs_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	task_t             mem_q [QDEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [PW:0]       cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == PW'(QDEPTH-1)) ? '0 : wptr_q + PW'(1);
			if (do_rd) rptr_q <= (rptr_q == PW'(QDEPTH-1)) ? '0 : rptr_q + PW'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + (PW+1)'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wdata;
	end

endmodule

### rtl/core/ffs_mul.sv
// Multi-cycle fixed point multiply with rounding and saturation, two partial products.
module ffs_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  ffs_pkg::mw_t a,
	input  ffs_pkg::vw_t b,
	output logic         done,
	output ffs_pkg::vw_t y
);
	import ffs_pkg::*;

	localparam int HALF   = V_W / 2;
	localparam int HI     = V_W - HALF;
	localparam int PW     = MA_W + HALF;
	localparam int ACC_MW = MA_W + V_W;

	logic [2:0]          ph_q;
	logic                done_q;
	logic [MA_W-1:0]     ua_q;
	logic [V_W-1:0]      ub_q;
	logic                neg_q;
	logic [PW-1:0]       prod_q;
	logic [ACC_MW-1:0]   acc_q;
	logic [LIM_BITS-1:0] mag_q;
	vw_t                 y_q;
	logic [ACC_MW-1:0]   rnd;
	logic [ACC_MW-1:0]   rsh;

	assign rnd  = acc_q + (ACC_MW'(1) << (FRAC_BITS - 1));
	assign rsh  = rnd >> FRAC_BITS;
	assign done = done_q;
	assign y    = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == 3'd5);
			if (start) ph_q <= 3'd1;
			else if (ph_q == 3'd5) ph_q <= 3'd0;
			else if (ph_q != 3'd0) ph_q <= ph_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
			ub_q  <= b[V_W-1] ? V_W'(-b) : V_W'(b);
			neg_q <= a[MA_W-1] ^ b[V_W-1];
		end
		unique case (ph_q)
			3'd1: prod_q <= PW'(ua_q) * PW'(ub_q[HALF-1:0]);
			3'd2: begin
				acc_q  <= ACC_MW'(prod_q);
				prod_q <= PW'(ua_q) * PW'(ub_q[V_W-1 -: HI]);
			end
			3'd3: acc_q <= acc_q + (ACC_MW'(prod_q) << HALF);
			3'd4: mag_q <= (|rsh[ACC_MW-1:LIM_BITS]) ? ILIM[LIM_BITS-1:0]
			                                          : rsh[LIM_BITS-1:0];
			3'd5: y_q <= neg_q ? -vw_t'(mag_q) : vw_t'(mag_q);
			default: ;
		endcase
	end

endmodule

### rtl/core/ffs_div3.sv
// Rounded division by 12 or 24: shift, then divide by three with a shift-add reciprocal.
module ffs_div3 (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  ffs_pkg::xw_t x,
	input  logic         by24,
	output logic         done,
	output ffs_pkg::vw_t y
);
	import ffs_pkg::*;

	localparam int DW      = 64;
	localparam int AW      = 2 * DW;
	localparam int BIAS12  = 6;
	localparam int BIAS24  = 12;
	localparam logic [3:0] PH_LAST = 4'd8;

	logic [3:0]     ph_q;
	logic           done_q;
	logic [DW-1:0]  t_q;
	logic [AW-1:0]  acc_q;
	logic [DW-1:0]  q_q;
	logic           neg_q;
	vw_t            y_q;
	logic [X_W-1:0] mx;
	logic [X_W-1:0] biased;
	logic [3:0]     rlo;

	assign mx     = x[X_W-1] ? X_W'(-x) : X_W'(x);
	assign biased = mx + X_W'(by24 ? BIAS24 : BIAS12);
	// estimate is floor(t/3) or one less, so the remainder is below 6
	assign rlo    = t_q[3:0] - q_q[3:0] - {q_q[2:0], 1'b0};
	assign done   = done_q;
	assign y      = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 4'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == PH_LAST);
			if (start) ph_q <= 4'd1;
			else if (ph_q == PH_LAST) ph_q <= 4'd0;
			else if (ph_q != 4'd0) ph_q <= ph_q + 4'd1;
		end
	end

	// t * 0x5555555555555555 built by doubling, upper half is the estimate
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= x[X_W-1];
			t_q   <= DW'(by24 ? (biased >> 3) : (biased >> 2));
		end
		unique case (ph_q)
			4'd1: acc_q <= AW'(t_q) + (AW'(t_q) << 2);
			4'd2: acc_q <= acc_q + (acc_q << 4);
			4'd3: acc_q <= acc_q + (acc_q << 8);
			4'd4: acc_q <= acc_q + (acc_q << 16);
			4'd5: acc_q <= acc_q + (acc_q << 32);
			4'd6: q_q   <= acc_q[AW-1 -: DW];
			4'd7: q_q   <= q_q + DW'(rlo >= 4'd3);
			4'd8: y_q   <= neg_q ? -vw_t'(q_q[V_W-1:0]) : vw_t'(q_q[V_W-1:0]);
			default: ;
		endcase
	end

endmodule

### rtl/core/ffs_back.sv
// Back end: sequences the flux arithmetic on a shared multiplier and divider.
module ffs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ffs_pkg::cfg_t     cfg,
	input  logic              task_valid,
	input  ffs_pkg::task_t    task_word,
	output logic              task_pop,
	output logic              res_valid,
	output ffs_pkg::out_word_t res,
	input  logic              res_pop
);
	import ffs_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [1:0] grp_q;
	logic [2:0] step_q;
	logic       res_valid_q;
	logic       kind_div_q;
	logic       by24_q;
	mw_t        opa_q;
	vw_t        opb_q;
	xw_t        opx_q;
	task_t      tk_q;
	vw_t        pterm_q, tmp_q, m1_q, m2_q, m3_q, conv_q;
	out_word_t  build_q;
	out_word_t  res_q;

	logic       mul_done, div_done, op_done;
	vw_t        mul_y, div_y, op_y;
	logic       last_step;

	logic       d_div, d_by24;
	mw_t        d_a;
	vw_t        d_b;
	xw_t        d_x;

	logic [1:0] nsel;
	word_t      ql, qll, qr, qrr, nl, nll, nr, nrr;
	mw_t        n1, n2, n3;
	xw_t        psum, inner_w, inner_c;

	assign nsel = normal_sel(cfg.axis);
	assign ql   = vel_sel(tk_q.l, grp_q);
	assign qll  = vel_sel(tk_q.ll, grp_q);
	assign qr   = vel_sel(tk_q.r, grp_q);
	assign qrr  = vel_sel(tk_q.rr, grp_q);
	assign nl   = vel_sel(tk_q.l, nsel);
	assign nll  = vel_sel(tk_q.ll, nsel);
	assign nr   = vel_sel(tk_q.r, nsel);
	assign nrr  = vel_sel(tk_q.rr, nsel);
	assign n1   = mw_t'(nl) + mw_t'(nr);
	assign n2   = mw_t'(nl) + mw_t'(nrr);
	assign n3   = mw_t'(nll) + mw_t'(nr);
	assign psum = xw_t'(tk_q.l.p) + xw_t'(tk_q.r.p);

	assign inner_w = xw_t'(conv_q) - xw_t'(tmp_q) + ((grp_q == nsel) ? xw_t'(pterm_q) : '0);
	always_comb begin
		inner_c = inner_w;
		if (inner_w > xw_t'(ILIM)) inner_c = xw_t'(ILIM);
		if (inner_w < -xw_t'(ILIM)) inner_c = -xw_t'(ILIM);
	end

	always_comb begin
		d_div  = 1'b0;
		d_by24 = 1'b0;
		d_a    = '0;
		d_b    = '0;
		d_x    = '0;
		if (grp_q == 2'd0) begin
			unique case (step_q)
				3'd0: begin
					d_div = 1'b1;
					d_x   = psum * 7 - xw_t'(tk_q.ll.p) - xw_t'(tk_q.rr.p);
				end
				3'd1: begin
					d_div = 1'b1;
					d_x   = (xw_t'(n1) <<< 3) - xw_t'(n2) - xw_t'(n3);
				end
				3'd2: begin
					d_a = mw_t'(cfg.compress_coef);
					d_b = tmp_q;
				end
				default: begin
					d_a = mw_t'(cfg.face_area);
					d_b = tmp_q;
				end
			endcase
		end else begin
			unique case (step_q)
				3'd0: begin
					d_a = mw_t'(ql) + mw_t'(qr);
					d_b = vw_t'(n1);
				end
				3'd1: begin
					d_a = mw_t'(ql) + mw_t'(qrr);
					d_b = vw_t'(n2);
				end
				3'd2: begin
					d_a = mw_t'(qll) + mw_t'(qr);
					d_b = vw_t'(n3);
				end
				3'd3: begin
					d_div  = 1'b1;
					d_by24 = 1'b1;
					d_x    = (xw_t'(m1_q) <<< 3) - xw_t'(m2_q) - xw_t'(m3_q);
				end
				3'd4: begin
					d_div = 1'b1;
					d_x   = (xw_t'(qr) - xw_t'(ql)) * 15 - (xw_t'(qrr) - xw_t'(qll));
				end
				3'd5: begin
					d_a = mw_t'(cfg.visc_coef);
					d_b = tmp_q;
				end
				default: begin
					d_a = mw_t'(cfg.face_area);
					d_b = vw_t'(inner_c);
				end
			endcase
		end
	end

	ffs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START && !kind_div_q),
		.a      (opa_q),
		.b      (opb_q),
		.done   (mul_done),
		.y      (mul_y)
	);

	ffs_div3 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START && kind_div_q),
		.x      (opx_q),
		.by24   (by24_q),
		.done   (div_done),
		.y      (div_y)
	);

	assign op_done   = mul_done || div_done;
	assign op_y      = kind_div_q ? div_y : mul_y;
	assign last_step = (grp_q == 2'd0) ? (step_q == 3'd3) : (step_q == 3'd6);
	assign task_pop  = (state_q == ST_IDLE) && task_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grp_q       <= 2'd0;
			step_q      <= 3'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!res_valid_q || res_pop)) res_valid_q <= 1'b1;
			else if (res_pop && res_valid_q) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (task_valid) begin
						grp_q   <= 2'd0;
						step_q  <= 3'd0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_START;
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (op_done) begin
						if (!last_step) begin
							step_q  <= step_q + 3'd1;
							state_q <= ST_ISSUE;
						end else if (grp_q == 2'd3) begin
							state_q <= ST_DONE;
						end else begin
							grp_q   <= grp_q + 2'd1;
							step_q  <= 3'd0;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_DONE: begin
					if (!res_valid_q || res_pop) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (task_pop) tk_q <= task_word;
		if (state_q == ST_ISSUE) begin
			kind_div_q <= d_div;
			by24_q     <= d_by24;
			opa_q      <= d_a;
			opb_q      <= d_b;
			opx_q      <= d_x;
		end
		if (state_q == ST_DONE && (!res_valid_q || res_pop)) res_q <= build_q;
		if (state_q == ST_WAIT && op_done) begin
			if (grp_q == 2'd0) begin
				unique case (step_q)
					3'd0:    pterm_q <= op_y;
					3'd1:    tmp_q   <= op_y;
					3'd2:    tmp_q   <= op_y;
					default: build_q.pressure_flux <= sat_word(op_y);
				endcase
			end else begin
				unique case (step_q)
					3'd0: m1_q   <= op_y;
					3'd1: m2_q   <= op_y;
					3'd2: m3_q   <= op_y;
					3'd3: conv_q <= op_y;
					3'd4: tmp_q  <= op_y;
					3'd5: tmp_q  <= op_y;
					default: begin
						unique case (grp_q)
							VEL_X:   build_q.xmom_flux <= sat_word(op_y);
							VEL_Y:   build_q.ymom_flux <= sat_word(op_y);
							default: build_q.zmom_flux <= sat_word(op_y);
						endcase
					end
				endcase
			end
		end
	end

endmodule

### rtl/core/face_flux_stencil_unit.sv
// Top level of the fourth-order central face flux unit.
//
//  channel | direction | handshake          | word
//  item    | in        | push / full        | in_word_t: line_start, pressure, vel_x/y/z
//  result  | out       | empty / pop        | out_word_t: pressure, x/y/z momentum flux
//  config  | in        | cfg_we, cfg_index  | cfg_data, 31 bits, no read-back
//
//  A cell that only fills the window is taken when the queue is not full.
//  A cell that completes the window becomes a task for the back end:
//  25 operations in turn, 17 multiplies and 8 divides by three, each
//  issued, started and awaited, between task pop and result write.
//  The front keeps taking cells while the two-entry task queue has room.
//  A finished result waits in the output register. Reset sets config
//  defaults and clears window count, queue, sequencer but not window cells.
module face_flux_stencil_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  ffs_pkg::in_word_t             item,
	output logic                          empty,
	input  logic                          pop,
	output ffs_pkg::out_word_t            result,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [ffs_pkg::COEF_W-1:0]    cfg_data
);
	import ffs_pkg::*;

	cfg_t  cfg_q;
	logic  task_push, task_full, task_valid, task_pop, res_valid;
	task_t task_in, task_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis          <= AXIS_X;
			cfg_q.compress_coef <= COMPRESS_RST;
			cfg_q.visc_coef     <= '0;
			cfg_q.face_area     <= AREA_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AXIS:     cfg_q.axis          <= cfg_data[1:0];
				REG_COMPRESS: cfg_q.compress_coef <= cfg_data;
				REG_VISC:     cfg_q.visc_coef     <= cfg_data;
				default:      cfg_q.face_area     <= cfg_data;
			endcase
		end
	end

	ffs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.task_push (task_push),
		.task_word (task_in),
		.task_full (task_full)
	);

	ffs_task_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (task_push),
		.wdata  (task_in),
		.full   (task_full),
		.rd     (task_pop),
		.valid  (task_valid),
		.rdata  (task_out)
	);

	ffs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.task_valid (task_valid),
		.task_word  (task_out),
		.task_pop   (task_pop),
		.res_valid  (res_valid),
		.res        (result),
		.res_pop    (pop)
	);

	assign empty = !res_valid;

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		task_pop |-> task_valid) else $error("task queue read while empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		task_push |-> !task_full) else $error("task queue written while full");

	a_full_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		task_full |-> task_valid) else $error("queue full without data");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result))) else $error("result word lost");

endmodule
